[rtl/als_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// als_pkg
// Shared types and constants for the addressable LED serialiser.
// ----------------------------------------------------------------------------
package als_pkg;

	localparam int MAX_PIXELS     = 8;
	localparam int PIX_IDX_W      = 3;
	localparam int PIX_CNT_W      = 4;
	localparam int PIXEL_W        = 24;
	localparam int BIT_CNT_W      = 5;
	localparam int TICK_W         = 16;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 16;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_SHOW  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_BUSY  = 2'd2
	} status_t;

	localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LATCH_LOW  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PIXELS     = 3'd4;

	typedef struct packed {
		logic [7:0]           zero_high;
		logic [7:0]           one_high;
		logic [7:0]           bit_period;
		logic [TICK_W-1:0]    latch_low;
		logic [PIX_CNT_W-1:0] pixels;
	} cfg_t;

	typedef struct packed {
		logic                 wr;
		logic                 clr;
		logic [PIX_IDX_W-1:0] addr;
		logic [PIXEL_W-1:0]   data;
	} store_req_t;

	typedef struct packed {
		logic    line_level;
		logic    busy;
		status_t status;
		logic    frame_done;
	} res_t;

endpackage

[rtl/als_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// als_if
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface als_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [2:0] led_addr;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, op, led_addr, red, green, blue, input ready);
	modport sink (input valid, op, led_addr, red, green, blue, output ready);
endinterface

interface als_res_if;
	logic       valid;
	logic       ready;
	logic       line_level;
	logic       busy_res;
	logic [1:0] status;
	logic       frame_done;

	modport source (output valid, line_level, busy_res, status, frame_done, input ready);
	modport sink (input valid, line_level, busy_res, status, frame_done, output ready);
endinterface

[rtl/addressable_led_serializer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addressable_led_serializer
// Single-wire RGB LED chain driver: pixel store, bit serialiser, latch low.
// ----------------------------------------------------------------------------
// An accepted request has its result in the output register in the cycle
// after it is accepted. Throughput: one request per cycle while the output
// register is empty or its previous result is taken in the same cycle.
// Reset: asynchronous, clears the sequencer, the store valid bits and the
// output register, and loads the configuration registers with their defaults.
module addressable_led_serializer (
	input  logic                                clk,
	input  logic                                arst_n,
	als_req_if.sink                             item,
	als_res_if.source                           result,
	input  logic                                cfg_we,
	input  logic [als_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [als_pkg::CFG_DATA_W-1:0]      cfg_data
);

	als_pkg::cfg_t                       cfg_q;
	als_pkg::store_req_t                 store_req;
	als_pkg::res_t                       res;
	logic [als_pkg::PIX_IDX_W-1:0]       rd_addr;
	logic [als_pkg::PIXEL_W-1:0]         rd_data;
	logic                                fire;
	logic                                out_vld_q;
	als_pkg::res_t                       res_q;

	assign item.ready = !out_vld_q || result.ready;
	assign fire       = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_high  <= 8'd14;
			cfg_q.one_high   <= 8'd43;
			cfg_q.bit_period <= 8'd58;
			cfg_q.latch_low  <= 16'd9600;
			cfg_q.pixels     <= 4'd7;
		end else if (cfg_we) begin
			case (cfg_index)
				als_pkg::REG_ZERO_HIGH:  cfg_q.zero_high  <= cfg_data[7:0];
				als_pkg::REG_ONE_HIGH:   cfg_q.one_high   <= cfg_data[7:0];
				als_pkg::REG_BIT_PERIOD: cfg_q.bit_period <= cfg_data[7:0];
				als_pkg::REG_LATCH_LOW:  cfg_q.latch_low  <= cfg_data[15:0];
				als_pkg::REG_PIXELS:     cfg_q.pixels     <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	als_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (store_req),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	als_tx u_tx (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.op          (als_pkg::op_t'(item.op)),
		.led_addr    (item.led_addr),
		.pixel_data  ({item.green, item.red, item.blue}),
		.cfg         (cfg_q),
		.rd_data     (rd_data),
		.rd_addr     (rd_addr),
		.store_req   (store_req),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fire) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (fire) begin
			res_q <= res;
		end
	end

	assign result.valid      = out_vld_q;
	assign result.line_level = res_q.line_level;
	assign result.busy_res   = res_q.busy;
	assign result.status     = res_q.status;
	assign result.frame_done = res_q.frame_done;

endmodule

[rtl/als_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// als_store
// Pixel store, GRB order. Per-entry valid bits let a clear empty every entry together.
// ----------------------------------------------------------------------------
module als_store (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  als_pkg::store_req_t                   req,
	input  logic [als_pkg::PIX_IDX_W-1:0]         rd_addr,
	output logic [als_pkg::PIXEL_W-1:0]           rd_data
);

	logic [als_pkg::PIXEL_W-1:0]    mem_q [als_pkg::MAX_PIXELS];
	logic [als_pkg::MAX_PIXELS-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem_q[req.addr] <= req.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.clr) begin
			vld_q <= '0;
		end else if (req.wr) begin
			vld_q[req.addr] <= 1'b1;
		end
	end

	assign rd_data = vld_q[rd_addr] ? mem_q[rd_addr] : '0;

endmodule

[rtl/als_tx.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// als_tx
// Frame sequencer: bit shift register, tick/bit/pixel counters, latch low.
// ----------------------------------------------------------------------------
module als_tx (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  fire,
	input  als_pkg::op_t                          op,
	input  logic [als_pkg::PIX_IDX_W-1:0]         led_addr,
	input  logic [als_pkg::PIXEL_W-1:0]           pixel_data,
	input  als_pkg::cfg_t                         cfg,
	input  logic [als_pkg::PIXEL_W-1:0]           rd_data,
	output logic [als_pkg::PIX_IDX_W-1:0]         rd_addr,
	output als_pkg::store_req_t                   store_req,
	output als_pkg::res_t                         res
);

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_SEND  = 2'd1,
		PH_LATCH = 2'd2
	} phase_t;

	phase_t                          phase_q, phase_n;
	logic [als_pkg::TICK_W-1:0]      tick_q, tick_n, tick_inc;
	logic [als_pkg::BIT_CNT_W-1:0]   bit_q, bit_n;
	logic [als_pkg::PIX_IDX_W-1:0]   pix_q, pix_n;
	logic [als_pkg::PIX_CNT_W-1:0]   pix_inc;
	logic [als_pkg::PIXEL_W-1:0]     shift_q, shift_n;
	logic [als_pkg::PIX_CNT_W-1:0]   active;
	logic [als_pkg::TICK_W-1:0]      period;
	logic [als_pkg::TICK_W-1:0]      latch_len;
	logic [7:0]                      hi_len;
	als_pkg::status_t                status;
	logic                            done;

	assign active    = (cfg.pixels > als_pkg::PIX_CNT_W'(als_pkg::MAX_PIXELS)) ?
	                   als_pkg::PIX_CNT_W'(als_pkg::MAX_PIXELS) : cfg.pixels;
	assign period    = (cfg.bit_period == 8'd0) ? als_pkg::TICK_W'(1) :
	                   {8'd0, cfg.bit_period};
	assign latch_len = (cfg.latch_low == '0) ? als_pkg::TICK_W'(1) : cfg.latch_low;
	assign tick_inc  = tick_q + als_pkg::TICK_W'(1);
	assign pix_inc   = {1'b0, pix_q} + als_pkg::PIX_CNT_W'(1);
	assign rd_addr   = (op == als_pkg::OP_SHOW) ? '0 : pix_inc[als_pkg::PIX_IDX_W-1:0];

	always_comb begin
		phase_n   = phase_q;
		tick_n    = tick_q;
		bit_n     = bit_q;
		pix_n     = pix_q;
		shift_n   = shift_q;
		status    = als_pkg::ST_OK;
		done      = 1'b0;
		store_req = '0;
		if (op == als_pkg::OP_TICK) begin
			case (phase_q)
				PH_SEND: begin
					if (tick_inc >= period) begin
						tick_n = '0;
						if (bit_q >= als_pkg::BIT_CNT_W'(als_pkg::PIXEL_W - 1)) begin
							bit_n = '0;
							pix_n = pix_inc[als_pkg::PIX_IDX_W-1:0];
							if (pix_inc >= active) begin
								phase_n = PH_LATCH;
							end else begin
								shift_n = rd_data;
							end
						end else begin
							bit_n   = bit_q + als_pkg::BIT_CNT_W'(1);
							shift_n = {shift_q[als_pkg::PIXEL_W-2:0], 1'b0};
						end
					end else begin
						tick_n = tick_inc;
					end
				end
				PH_LATCH: begin
					if (tick_inc >= latch_len) begin
						tick_n  = '0;
						phase_n = PH_IDLE;
						done    = 1'b1;
					end else begin
						tick_n = tick_inc;
					end
				end
				default: begin
				end
			endcase
		end else if (phase_q != PH_IDLE) begin
			status = als_pkg::ST_BUSY;
		end else begin
			case (op)
				als_pkg::OP_WRITE: begin
					if ({1'b0, led_addr} >= active) begin
						status = als_pkg::ST_RANGE;
					end else begin
						store_req.wr   = fire;
						store_req.addr = led_addr;
						store_req.data = pixel_data;
					end
				end
				als_pkg::OP_SHOW: begin
					pix_n  = '0;
					bit_n  = '0;
					tick_n = '0;
					if (active == '0) begin
						shift_n = '0;
						phase_n = PH_LATCH;
					end else begin
						shift_n = rd_data;
						phase_n = PH_SEND;
					end
				end
				als_pkg::OP_CLEAR: begin
					store_req.clr = fire;
				end
				default: begin
				end
			endcase
		end
	end

	assign hi_len = shift_n[als_pkg::PIXEL_W-1] ? cfg.one_high : cfg.zero_high;

	always_comb begin
		res.line_level = (phase_n == PH_SEND) && (tick_n < {8'd0, hi_len});
		res.busy       = (phase_n != PH_IDLE);
		res.status     = status;
		res.frame_done = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			pix_q   <= '0;
			shift_q <= '0;
		end else if (fire) begin
			phase_q <= phase_n;
			tick_q  <= tick_n;
			bit_q   <= bit_n;
			pix_q   <= pix_n;
			shift_q <= shift_n;
		end
	end

endmodule

[tb/sv/tb_addressable_led_serializer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_addressable_led_serializer
// Self-checking bench for the LED chain serialiser. A cycle-level shadow of
// the pixel store, the bit sequencer and the latch low predicts the line
// level, busy flag, status and frame end for every accepted request. Directed
// checks of each operation and of the pixel count limits come first. Random
// frames follow under changing timing and changing back-pressure, with one
// frame whose one-bit high pulse fills the bit period, sent back to back.
// ----------------------------------------------------------------------------
module tb_addressable_led_serializer;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PRINT_LIMIT    = 50;

	typedef enum logic [1:0] {
		LED_IDLE,
		LED_SEND,
		LED_LATCH
	} led_phase_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [als_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [als_pkg::CFG_DATA_W-1:0] cfg_data;

	als_req_if req_ch();
	als_res_if res_ch();

	addressable_led_serializer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (req_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow of the block
	als_pkg::cfg_t               led_cfg;
	logic [als_pkg::PIXEL_W-1:0] pix_mem [als_pkg::MAX_PIXELS];
	logic [als_pkg::PIXEL_W-1:0] shift_reg;
	int                          pix_no;
	int                          bit_no;
	logic [als_pkg::TICK_W-1:0]  tick_no;
	led_phase_t                  led_phase;

	als_pkg::res_t due_results [$];
	int            mismatches;
	int            requests_sent;
	int            stall_cycles;
	int            src_gap_pct;
	int            snk_stall_pct;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	function automatic int lit_count();
		return (led_cfg.pixels > als_pkg::MAX_PIXELS) ? als_pkg::MAX_PIXELS :
			int'(led_cfg.pixels);
	endfunction

	function automatic int period_len();
		return (led_cfg.bit_period == 8'd0) ? 1 : int'(led_cfg.bit_period);
	endfunction

	function automatic int latch_len();
		return (led_cfg.latch_low == '0) ? 1 : int'(led_cfg.latch_low);
	endfunction

	function automatic int ticks_until_idle();
		case (led_phase)
			LED_SEND: begin
				return (period_len() - int'(tick_no))
					+ ((23 - bit_no) + (lit_count() - 1 - pix_no) * 24) * period_len()
					+ latch_len();
			end
			LED_LATCH: return latch_len() - int'(tick_no);
			default: return 0;
		endcase
	endfunction

	function automatic als_pkg::res_t step_led_chain(input als_pkg::op_t op,
			input logic [2:0] idx, input logic [7:0] red, input logic [7:0] green,
			input logic [7:0] blue);
		als_pkg::res_t    r;
		als_pkg::status_t st;
		logic             done;
		logic [7:0]       high_len;
		st = als_pkg::ST_OK;
		done = 1'b0;
		if (op == als_pkg::OP_TICK) begin
			if (led_phase == LED_SEND) begin
				tick_no = tick_no + 16'd1;
				if (int'(tick_no) >= period_len()) begin
					tick_no = '0;
					bit_no++;
					if (bit_no >= 24) begin
						bit_no = 0;
						pix_no++;
						if (pix_no >= lit_count()) begin
							led_phase = LED_LATCH;
							bit_no = 0;
						end else begin
							shift_reg = pix_mem[pix_no];
						end
					end else begin
						shift_reg = {shift_reg[als_pkg::PIXEL_W-2:0], 1'b0};
					end
				end
			end else if (led_phase == LED_LATCH) begin
				tick_no = tick_no + 16'd1;
				if (int'(tick_no) >= latch_len()) begin
					tick_no = '0;
					led_phase = LED_IDLE;
					done = 1'b1;
				end
			end
		end else if (led_phase != LED_IDLE) begin
			st = als_pkg::ST_BUSY;
		end else begin
			case (op)
				als_pkg::OP_WRITE: begin
					if (int'(idx) >= lit_count())
						st = als_pkg::ST_RANGE;
					else
						pix_mem[idx] = {green, red, blue};
				end
				als_pkg::OP_SHOW: begin
					pix_no = 0;
					bit_no = 0;
					tick_no = '0;
					if (lit_count() == 0) begin
						shift_reg = '0;
						led_phase = LED_LATCH;
					end else begin
						shift_reg = pix_mem[0];
						led_phase = LED_SEND;
					end
				end
				als_pkg::OP_CLEAR: begin
					for (int i = 0; i < als_pkg::MAX_PIXELS; i++)
						pix_mem[i] = '0;
				end
				default: ;
			endcase
		end
		high_len = shift_reg[als_pkg::PIXEL_W-1] ? led_cfg.one_high : led_cfg.zero_high;
		r.line_level = (led_phase == LED_SEND) && (tick_no < {8'd0, high_len});
		r.busy = (led_phase != LED_IDLE);
		r.status = st;
		r.frame_done = done;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("%0t ns: %s got %0d, expected %0d", $time, what, got, want);
	endtask

	always @(posedge clk) begin
		als_pkg::res_t due;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (due_results.size() == 0) begin
					report_mismatch("result with no request waiting", 1, 0);
				end else begin
					due = due_results.pop_front();
					if (res_ch.line_level !== due.line_level)
						report_mismatch("line_level", res_ch.line_level, due.line_level);
					if (res_ch.busy_res !== due.busy)
						report_mismatch("busy_res", res_ch.busy_res, due.busy);
					if (res_ch.status !== due.status)
						report_mismatch("status", res_ch.status, due.status);
					if (res_ch.frame_done !== due.frame_done)
						report_mismatch("frame_done", res_ch.frame_done, due.frame_done);
				end
			end
			if (req_ch.valid && req_ch.ready)
				due_results.push_back(step_led_chain(als_pkg::op_t'(req_ch.op),
					req_ch.led_addr, req_ch.red, req_ch.green, req_ch.blue));
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	function automatic logic [7:0] rand_byte();
		return 8'($urandom);
	endfunction

	task automatic send_item(input als_pkg::op_t op, input logic [2:0] idx,
			input logic [7:0] red, input logic [7:0] green, input logic [7:0] blue);
		while ($urandom_range(99) < src_gap_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.led_addr <= idx;
		req_ch.red <= red;
		req_ch.green <= green;
		req_ch.blue <= blue;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		requests_sent++;
	endtask

	task automatic send_tick();
		send_item(als_pkg::OP_TICK, 3'($urandom_range(7)), rand_byte(), rand_byte(),
			rand_byte());
	endtask

	task automatic send_op(input als_pkg::op_t op, input logic [2:0] idx);
		send_item(op, idx, rand_byte(), rand_byte(), rand_byte());
	endtask

	// sender holds off until every outstanding request has its result
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (due_results.size() != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [als_pkg::CFG_IDX_W-1:0] idx,
			input logic [als_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			als_pkg::REG_ZERO_HIGH:  led_cfg.zero_high = val[7:0];
			als_pkg::REG_ONE_HIGH:   led_cfg.one_high = val[7:0];
			als_pkg::REG_BIT_PERIOD: led_cfg.bit_period = val[7:0];
			als_pkg::REG_LATCH_LOW:  led_cfg.latch_low = val;
			als_pkg::REG_PIXELS:     led_cfg.pixels = val[als_pkg::PIX_CNT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_timing(input logic [7:0] zero_high, input logic [7:0] one_high,
			input logic [7:0] period, input logic [15:0] latch, input logic [3:0] pixels);
		drain_results();
		write_reg(als_pkg::REG_ZERO_HIGH, {8'd0, zero_high});
		write_reg(als_pkg::REG_ONE_HIGH, {8'd0, one_high});
		write_reg(als_pkg::REG_BIT_PERIOD, {8'd0, period});
		write_reg(als_pkg::REG_LATCH_LOW, latch);
		write_reg(als_pkg::REG_PIXELS, {12'd0, pixels});
	endtask

	task automatic finish_frame();
		int n;
		drain_results();
		n = ticks_until_idle();
		while (n > 0) begin
			repeat (n) send_tick();
			drain_results();
			n = ticks_until_idle();
		end
	endtask

	task automatic write_random_pixel();
		int idx;
		if (lit_count() > 0 && $urandom_range(4) != 0)
			idx = $urandom_range(lit_count() - 1);
		else
			idx = $urandom_range(7);
		send_op(als_pkg::OP_WRITE, 3'(idx));
	endtask

	task automatic random_timing();
		int         pick;
		int         pixels;
		logic [7:0] zero_high;
		logic [7:0] one_high;
		pick = $urandom_range(9);
		if (pick == 0)
			pixels = 0;
		else if (pick == 1)
			pixels = $urandom_range(15, 9);
		else
			pixels = $urandom_range(3, 1);
		zero_high = ($urandom_range(7) == 0) ? 8'd255 : 8'($urandom_range(7));
		one_high = ($urandom_range(7) == 0) ? 8'd255 : 8'($urandom_range(7));
		set_timing(zero_high, one_high, 8'($urandom_range(6)), 16'($urandom_range(12)),
			4'(pixels));
	endtask

	task automatic play_random_frame();
		int n;
		repeat ($urandom_range(5)) write_random_pixel();
		if ($urandom_range(7) == 0) begin
			send_op(als_pkg::OP_CLEAR, 3'($urandom_range(7)));
			write_random_pixel();
		end
		if ($urandom_range(3) == 0)
			send_op(als_pkg::op_t'(2'($urandom_range(3))), 3'($urandom_range(7)));
		send_op(als_pkg::OP_SHOW, 3'($urandom_range(7)));
		drain_results();
		n = ticks_until_idle();
		repeat (n) begin
			if ($urandom_range(11) == 0)
				send_op(als_pkg::op_t'(2'($urandom_range(3, 1))), 3'($urandom_range(7)));
			send_tick();
		end
		repeat ($urandom_range(2)) send_tick();
		finish_frame();
	endtask

	task automatic test_basic_ops();
		// reset timing: seven pixels in use
		send_item(als_pkg::OP_WRITE, 3'd6, 8'h01, 8'h02, 8'h03);
		send_item(als_pkg::OP_WRITE, 3'd7, 8'hff, 8'hff, 8'hff);
		set_timing(8'd0, 8'd255, 8'd0, 16'd0, 4'd2);
		send_tick();
		send_item(als_pkg::OP_WRITE, 3'd0, 8'hff, 8'hff, 8'hff);
		send_item(als_pkg::OP_WRITE, 3'd1, 8'h80, 8'h00, 8'h01);
		send_item(als_pkg::OP_WRITE, 3'd2, 8'h00, 8'h00, 8'h00);
		send_item(als_pkg::OP_WRITE, 3'd7, 8'hff, 8'hff, 8'hff);
		send_op(als_pkg::OP_CLEAR, 3'd0);
		send_item(als_pkg::OP_WRITE, 3'd0, 8'ha5, 8'h5a, 8'hc3);
		send_op(als_pkg::OP_SHOW, 3'd0);
		send_item(als_pkg::OP_WRITE, 3'd1, 8'hff, 8'hff, 8'hff);
		send_op(als_pkg::OP_SHOW, 3'd0);
		send_op(als_pkg::OP_CLEAR, 3'd0);
		send_tick();
		finish_frame();
	endtask

	task automatic test_pixel_count_limits();
		// no pixels: straight into the latch low, every write out of range
		set_timing(8'd1, 8'd2, 8'd1, 16'd1, 4'd0);
		send_item(als_pkg::OP_WRITE, 3'd0, 8'h12, 8'h34, 8'h56);
		send_op(als_pkg::OP_SHOW, 3'd3);
		send_item(als_pkg::OP_WRITE, 3'd0, 8'h12, 8'h34, 8'h56);
		send_tick();
		send_tick();
		// counts above the store size saturate
		set_timing(8'd1, 8'd2, 8'd1, 16'd1, 4'd9);
		send_item(als_pkg::OP_WRITE, 3'd7, 8'h81, 8'h7e, 8'h18);
		send_op(als_pkg::OP_SHOW, 3'd0);
		finish_frame();
		set_timing(8'd1, 8'd1, 8'd1, 16'd2, 4'd15);
		send_op(als_pkg::OP_SHOW, 3'd0);
		finish_frame();
	endtask

	task automatic test_random_frames(input int target);
		int first;
		first = requests_sent;
		while (requests_sent - first < target) begin
			if ($urandom_range(2) == 0)
				random_timing();
			play_random_frame();
		end
	endtask

	task automatic test_long_pulse_frame();
		// one pulse a tick short of the period, the other filling it
		set_timing(8'd4, 8'd5, 8'd5, 16'd3, 4'd1);
		send_item(als_pkg::OP_WRITE, 3'd0, 8'h96, 8'h3c, 8'hc5);
		send_op(als_pkg::OP_SHOW, 3'd0);
		finish_frame();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= als_pkg::REG_ZERO_HIGH;
		cfg_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.op <= als_pkg::OP_TICK;
		req_ch.led_addr <= '0;
		req_ch.red <= '0;
		req_ch.green <= '0;
		req_ch.blue <= '0;
		led_cfg.zero_high = 8'd14;
		led_cfg.one_high = 8'd43;
		led_cfg.bit_period = 8'd58;
		led_cfg.latch_low = 16'd9600;
		led_cfg.pixels = 4'd7;
		for (int i = 0; i < als_pkg::MAX_PIXELS; i++)
			pix_mem[i] = '0;
		shift_reg = '0;
		pix_no = 0;
		bit_no = 0;
		tick_no = '0;
		led_phase = LED_IDLE;
		mismatches = 0;
		requests_sent = 0;
		stall_cycles = 0;
		src_gap_pct = 15;
		snk_stall_pct = 61;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_pixel_count_limits();
		test_random_frames(100);

		src_gap_pct = 61;
		snk_stall_pct = 15;
		test_random_frames(100);

		src_gap_pct = 0;
		snk_stall_pct = 0;
		test_long_pulse_frame();
		test_random_frames(100);

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && due_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[files.f]
rtl/als_pkg.sv
rtl/als_if.sv
rtl/als_store.sv
rtl/als_tx.sv
rtl/addressable_led_serializer.sv
tb/sv/tb_addressable_led_serializer.sv
